### sv/ocp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocp_pkg
// Shared widths, codes and controller/datapath interface types for the
// order crossover block.
// ----------------------------------------------------------------------------
package ocp_pkg;

  // Field widths fixed by the item format
  localparam int NODE_W = 6;
  localparam int CFG_W  = 7;
  localparam int NODE_DEPTH = 1 << NODE_W;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // write both parent stores
    logic run;         // latch cuts, clear taken and filled maps
    logic copy_rd;     // read first parent at idx
    logic copy_wr;     // place first parent node at idx
    logic fill_init;   // set up fill pointers after the segment
    logic fill_rd;     // read second parent at ppos
    logic fill_chk;    // place node if untaken, advance pointers
    logic emit_start;  // latch malformed flag, rewind idx
    logic emit_rd;     // read child at idx
    logic emit_step;   // advance to next child position
  } ocp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic copy_last;   // idx is the segment end
    logic fill_done;   // child complete or scan bound hit
    logic emit_last;   // idx is the final position
  } ocp_status_t;

endpackage

### sv/ocp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ocp_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/ocp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocp_ctrl
// Sequencer for the order crossover: load, segment copy, fill scan and
// child emission.
// ----------------------------------------------------------------------------
module ocp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  output logic                out_valid,
  input  logic                out_ready,
  input  ocp_pkg::ocp_status_t status,
  output ocp_pkg::ocp_cmd_t   cmd
);

  typedef enum logic [6:0] {
    IDLE     = 7'b0000001,
    COPY_RD  = 7'b0000010,
    COPY_WR  = 7'b0000100,
    FILL_RD  = 7'b0001000,
    FILL_CHK = 7'b0010000,
    EMIT_RD  = 7'b0100000,
    EMIT_OUT = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == IDLE);
  assign out_valid = (state == EMIT_OUT);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          if (kind == ocp_pkg::KIND_RUN) begin
            cmd.run    = 1'b1;
            state_next = COPY_RD;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_next  = COPY_WR;
      end
      COPY_WR: begin
        cmd.copy_wr = 1'b1;
        if (status.copy_last) begin
          cmd.fill_init = 1'b1;
          state_next    = FILL_RD;
        end else begin
          state_next = COPY_RD;
        end
      end
      FILL_RD: begin
        if (status.fill_done) begin
          cmd.emit_start = 1'b1;
          state_next     = EMIT_RD;
        end else begin
          cmd.fill_rd = 1'b1;
          state_next  = FILL_CHK;
        end
      end
      FILL_CHK: begin
        cmd.fill_chk = 1'b1;
        state_next   = FILL_RD;
      end
      EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = EMIT_OUT;
      end
      EMIT_OUT: begin
        if (out_ready) begin
          if (status.emit_last) begin
            state_next = IDLE;
          end else begin
            cmd.emit_step = 1'b1;
            state_next    = EMIT_RD;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/ocp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocp_datapath
// Parent and child stores, taken and filled maps, cut handling and the
// position pointers of the order crossover.
// ----------------------------------------------------------------------------
module ocp_datapath #(
  parameter int MAX_NODES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ocp_pkg::ocp_cmd_t            cmd,
  output ocp_pkg::ocp_status_t         status,
  input  logic                         node_count_write,
  input  logic [ocp_pkg::CFG_W-1:0]    node_count,
  input  logic [ocp_pkg::NODE_W-1:0]   position,
  input  logic [ocp_pkg::NODE_W-1:0]   first_parent_node,
  input  logic [ocp_pkg::NODE_W-1:0]   second_parent_node,
  input  logic [ocp_pkg::NODE_W-1:0]   cut_start,
  input  logic [ocp_pkg::NODE_W-1:0]   cut_end,
  output logic [ocp_pkg::NODE_W-1:0]   child_position,
  output logic [ocp_pkg::NODE_W-1:0]   child_node,
  output logic                         last,
  output logic                         malformed
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [ocp_pkg::CFG_W-1:0] MAX_C = ocp_pkg::CFG_W'(MAX_NODES);

  // Configuration and run registers
  logic [ocp_pkg::CFG_W-1:0]     count_cfg;
  logic [AW-1:0]                 n_m1;
  logic [AW-1:0]                 lo;
  logic [AW-1:0]                 hi;
  logic [AW-1:0]                 idx;
  logic [AW-1:0]                 cpos;
  logic [AW-1:0]                 ppos;
  logic [CW-1:0]                 reads;
  logic                          bad;
  logic [ocp_pkg::NODE_DEPTH-1:0] taken;
  logic [MAX_NODES-1:0]          filled;

  // Combinational helpers
  logic [AW-1:0]                 n_m1_c;
  logic [AW-1:0]                 cs_c;
  logic [AW-1:0]                 ce_c;
  logic [ocp_pkg::CFG_W-1:0]     n_m1_w;
  logic [CW-1:0]                 n_c;
  logic [AW-1:0]                 cpos_inc;
  logic [AW-1:0]                 ppos_inc;
  logic [AW-1:0]                 hi_inc;
  logic                          node_free;
  logic                          load_ok;

  // RAM ports
  logic [ocp_pkg::NODE_W-1:0]    p1_rd;
  logic [ocp_pkg::NODE_W-1:0]    p2_rd;
  logic [ocp_pkg::NODE_W-1:0]    c_rd;
  logic                          c_we;
  logic [AW-1:0]                 c_waddr;
  logic [ocp_pkg::NODE_W-1:0]    c_wdata;

  // Node count config register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_cfg <= ocp_pkg::CFG_W'(64);
    end else if (node_count_write) begin
      count_cfg <= node_count;
    end
  end

  // Effective count minus one, zero acts as one, capped at MAX_NODES
  always_comb begin
    if (count_cfg == '0) begin
      n_m1_c = '0;
    end else if (count_cfg > MAX_C) begin
      n_m1_c = AW'(MAX_NODES - 1);
    end else begin
      n_m1_c = AW'(count_cfg - ocp_pkg::CFG_W'(1));
    end
  end

  // Clamp cut points to count minus one
  assign n_m1_w = ocp_pkg::CFG_W'(n_m1_c);
  assign cs_c = (ocp_pkg::CFG_W'(cut_start) > n_m1_w) ? n_m1_c : AW'(cut_start);
  assign ce_c = (ocp_pkg::CFG_W'(cut_end) > n_m1_w) ? n_m1_c : AW'(cut_end);

  // Cyclic increments
  assign cpos_inc = (cpos == n_m1) ? '0 : cpos + AW'(1);
  assign ppos_inc = (ppos == n_m1) ? '0 : ppos + AW'(1);
  assign hi_inc   = (hi == n_m1) ? '0 : hi + AW'(1);
  assign n_c      = CW'(n_m1) + CW'(1);

  assign node_free = !taken[p2_rd];
  assign load_ok   = (ocp_pkg::CFG_W'(position) < MAX_C);

  // Status to controller
  assign status.copy_last = (idx == hi);
  assign status.fill_done = (cpos == lo) || (reads == n_c);
  assign status.emit_last = (idx == n_m1);

  // Run registers and pointers
  always_ff @(posedge clk) begin
    if (cmd.run) begin
      n_m1 <= n_m1_c;
      if (cs_c > ce_c) begin
        lo  <= ce_c;
        hi  <= cs_c;
        idx <= ce_c;
      end else begin
        lo  <= cs_c;
        hi  <= ce_c;
        idx <= cs_c;
      end
    end
    if (cmd.copy_wr) begin
      idx <= idx + AW'(1);
    end
    if (cmd.fill_init) begin
      cpos  <= hi_inc;
      ppos  <= hi_inc;
      reads <= '0;
    end
    if (cmd.fill_chk) begin
      if (node_free) begin
        cpos <= cpos_inc;
      end
      ppos  <= ppos_inc;
      reads <= reads + CW'(1);
    end
    if (cmd.emit_start) begin
      bad <= (cpos != lo);
      idx <= '0;
    end
    if (cmd.emit_step) begin
      idx <= idx + AW'(1);
    end
  end

  // Taken and filled maps, cleared at each run
  always_ff @(posedge clk) begin
    if (rst || cmd.run) begin
      taken  <= '0;
      filled <= '0;
    end else if (cmd.copy_wr) begin
      taken[p1_rd] <= 1'b1;
      filled[idx]  <= 1'b1;
    end else if (cmd.fill_chk && node_free) begin
      taken[p2_rd] <= 1'b1;
      filled[cpos] <= 1'b1;
    end
  end

  // Child store write select
  always_comb begin
    c_we    = 1'b0;
    c_waddr = idx;
    c_wdata = p1_rd;
    if (cmd.copy_wr) begin
      c_we = 1'b1;
    end else if (cmd.fill_chk && node_free) begin
      c_we    = 1'b1;
      c_waddr = cpos;
      c_wdata = p2_rd;
    end
  end

  ocp_ram #(.WIDTH(ocp_pkg::NODE_W), .DEPTH(MAX_NODES)) u_first_parent (
    .clk   (clk),
    .we    (cmd.load && load_ok),
    .waddr (AW'(position)),
    .wdata (first_parent_node),
    .re    (cmd.copy_rd),
    .raddr (idx),
    .rdata (p1_rd)
  );

  ocp_ram #(.WIDTH(ocp_pkg::NODE_W), .DEPTH(MAX_NODES)) u_second_parent (
    .clk   (clk),
    .we    (cmd.load && load_ok),
    .waddr (AW'(position)),
    .wdata (second_parent_node),
    .re    (cmd.fill_rd),
    .raddr (ppos),
    .rdata (p2_rd)
  );

  ocp_ram #(.WIDTH(ocp_pkg::NODE_W), .DEPTH(MAX_NODES)) u_child (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (cmd.emit_rd),
    .raddr (idx),
    .rdata (c_rd)
  );

  // Result fields, empty positions read as zero
  assign child_position = ocp_pkg::NODE_W'(idx);
  assign child_node     = filled[idx] ? c_rd : '0;
  assign last           = (idx == n_m1);
  assign malformed      = bad;

endmodule

### sv/order_crossover_permutation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_crossover_permutation
// Order crossover (OX1) of two tour permutations held in on-chip stores.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | kind, position, first_parent_node,
//           |                      | second_parent_node, cut_start, cut_end
//   out     | out_valid/out_ready  | child_position, child_node, last,
//           |                      | malformed
//   config  | node_count_write     | node_count
//
// A load item is accepted in IDLE and leaves the block ready. A run item is
// accepted, then copies the segment (a read and a write per position),
// scans the second parent (a read and a check per read, at most node count
// reads), closes the scan and emits each result (a registered read, then the
// offer). Input is held off for the whole run. Output stalls simply extend
// the run. Reset restores node count to 64.
// ----------------------------------------------------------------------------
module order_crossover_permutation #(
  parameter int MAX_NODES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       node_count_write,
  input  logic [ocp_pkg::CFG_W-1:0]  node_count,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       kind,
  input  logic [ocp_pkg::NODE_W-1:0] position,
  input  logic [ocp_pkg::NODE_W-1:0] first_parent_node,
  input  logic [ocp_pkg::NODE_W-1:0] second_parent_node,
  input  logic [ocp_pkg::NODE_W-1:0] cut_start,
  input  logic [ocp_pkg::NODE_W-1:0] cut_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ocp_pkg::NODE_W-1:0] child_position,
  output logic [ocp_pkg::NODE_W-1:0] child_node,
  output logic                       last,
  output logic                       malformed
);

  ocp_pkg::ocp_cmd_t    cmd;
  ocp_pkg::ocp_status_t status;

  ocp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ocp_datapath #(.MAX_NODES(MAX_NODES)) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .node_count_write   (node_count_write),
    .node_count         (node_count),
    .position           (position),
    .first_parent_node  (first_parent_node),
    .second_parent_node (second_parent_node),
    .cut_start          (cut_start),
    .cut_end            (cut_end),
    .child_position     (child_position),
    .child_node         (child_node),
    .last               (last),
    .malformed          (malformed)
  );

endmodule

### sv/ocp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocp_checker
// Port-level checks for the order crossover, bound to the top level.
// ----------------------------------------------------------------------------
module ocp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ocp_pkg::NODE_W-1:0] child_position,
  input logic [ocp_pkg::NODE_W-1:0] child_node,
  input logic                       last,
  input logic                       malformed
);

  // No new item is taken while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result offered");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(child_position) && $stable(child_node)
       && $stable(last) && $stable(malformed)))
    else $error("stalled result changed");

  // The last result ends the run
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (!out_valid && in_ready))
    else $error("result after last");

  // Results step through positions with one malformed flag per run
  a_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |-> ##2
      (out_valid && child_position == $past(child_position, 2) + 6'd1
       && malformed == $past(malformed, 2)))
    else $error("result position did not advance");

endmodule

bind order_crossover_permutation ocp_checker u_ocp_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .child_position (child_position),
  .child_node     (child_node),
  .last           (last),
  .malformed      (malformed)
);

### tb/order_crossover_permutation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_crossover_permutation_tb
// Self-checking bench for the order crossover block. A short table of
// directed items (single-node tours, clamped and swapped cuts, a second
// parent with a repeated node) runs first. After it come random phases, each
// at a new node count: well-formed parent pairs, runs with random cuts, and
// the odd corrupted load. Every child item is checked against a crossover
// predictor or typed table items. Sender and receiver throttle in three modes.
// ----------------------------------------------------------------------------
module order_crossover_permutation_tb;

  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int PLAN_LEN     = 18;

  typedef struct packed {
    logic [ocp_pkg::NODE_W-1:0] position;
    logic [ocp_pkg::NODE_W-1:0] node;
    logic                       last;
    logic                       malformed;
  } child_item_t;

  // One directed item, optionally preceded by a node count write.
  // typed_count > 0 means the child is typed in below instead of predicted.
  typedef struct {
    bit                         set_count;
    logic [ocp_pkg::CFG_W-1:0]  count_value;
    logic                       op;
    logic [ocp_pkg::NODE_W-1:0] pos;
    logic [ocp_pkg::NODE_W-1:0] node_a;
    logic [ocp_pkg::NODE_W-1:0] node_b;
    logic [ocp_pkg::NODE_W-1:0] cut_s;
    logic [ocp_pkg::NODE_W-1:0] cut_e;
    int                         typed_count;
    logic [ocp_pkg::NODE_W-1:0] node0;
    logic [ocp_pkg::NODE_W-1:0] node1;
    logic                       bad;
  } plan_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       node_count_write = 1'b0;
  logic [ocp_pkg::CFG_W-1:0]  node_count = 7'd64;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       kind = ocp_pkg::KIND_LOAD;
  logic [ocp_pkg::NODE_W-1:0] position = '0;
  logic [ocp_pkg::NODE_W-1:0] first_parent_node = '0;
  logic [ocp_pkg::NODE_W-1:0] second_parent_node = '0;
  logic [ocp_pkg::NODE_W-1:0] cut_start = '0;
  logic [ocp_pkg::NODE_W-1:0] cut_end = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [ocp_pkg::NODE_W-1:0] child_position;
  logic [ocp_pkg::NODE_W-1:0] child_node;
  logic                       last;
  logic                       malformed;

  // Bench copy of the parent stores and the node count
  logic [ocp_pkg::NODE_W-1:0] tour_a [ocp_pkg::NODE_DEPTH];
  logic [ocp_pkg::NODE_W-1:0] tour_b [ocp_pkg::NODE_DEPTH];
  logic [ocp_pkg::CFG_W-1:0]  node_setting = 7'd64;
  bit                         tours_whole = 1'b0;

  child_item_t awaited_children [$];
  int          items_sent = 0;
  int          mismatches = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;

  plan_row_t plan [PLAN_LEN] = '{
    // single node tour: child is the first parent's only node
    '{1, 1, ocp_pkg::KIND_LOAD, 0, 63, 0, 63, 63, 0, 0, 0, 0},
    '{0, 0, ocp_pkg::KIND_RUN, 63, 0, 63, 0, 0, 1, 63, 0, 0},
    '{0, 0, ocp_pkg::KIND_RUN, 0, 63, 63, 63, 63, 1, 63, 0, 0},
    // node count zero acts as one
    '{1, 0, ocp_pkg::KIND_RUN, 0, 0, 0, 63, 0, 1, 63, 0, 0},
    // second parent repeats a node: scan bound hit, empty slot reads zero
    '{1, 2, ocp_pkg::KIND_LOAD, 0, 5, 5, 0, 0, 0, 0, 0, 0},
    '{0, 0, ocp_pkg::KIND_LOAD, 1, 9, 5, 63, 63, 0, 0, 0, 0},
    '{0, 0, ocp_pkg::KIND_RUN, 0, 0, 0, 0, 0, 2, 5, 0, 1},
    '{0, 0, ocp_pkg::KIND_RUN, 0, 0, 0, 63, 0, 2, 5, 9, 0},
    // reversed parents, cuts out of order
    '{0, 0, ocp_pkg::KIND_LOAD, 0, 63, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, ocp_pkg::KIND_LOAD, 1, 0, 63, 0, 0, 0, 0, 0, 0},
    '{0, 0, ocp_pkg::KIND_RUN, 0, 0, 0, 1, 0, 2, 63, 0, 0},
    '{0, 0, ocp_pkg::KIND_RUN, 0, 0, 0, 1, 1, 2, 63, 0, 0},
    // three nodes, first with mismatched node sets, then a proper pair
    '{1, 3, ocp_pkg::KIND_LOAD, 2, 42, 21, 0, 0, 0, 0, 0, 0},
    '{0, 0, ocp_pkg::KIND_RUN, 0, 0, 0, 2, 2, 0, 0, 0, 0},
    '{0, 0, ocp_pkg::KIND_RUN, 0, 0, 0, 0, 2, 0, 0, 0, 0},
    '{0, 0, ocp_pkg::KIND_LOAD, 2, 42, 42, 0, 0, 0, 0, 0, 0},
    '{0, 0, ocp_pkg::KIND_RUN, 0, 0, 0, 2, 0, 0, 0, 0, 0},
    '{0, 0, ocp_pkg::KIND_RUN, 0, 0, 0, 1, 1, 0, 0, 0, 0}
  };

  order_crossover_permutation i_dut (
    .clk                (clk),
    .rst                (rst),
    .node_count_write   (node_count_write),
    .node_count         (node_count),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .kind               (kind),
    .position           (position),
    .first_parent_node  (first_parent_node),
    .second_parent_node (second_parent_node),
    .cut_start          (cut_start),
    .cut_end            (cut_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .child_position     (child_position),
    .child_node         (child_node),
    .last               (last),
    .malformed          (malformed)
  );

  // 4 ns clock
  always begin
    #2;
    clk = 1'b1;
    #2;
    clk = 1'b0;
  end

  function automatic int unsigned active_nodes(input logic [ocp_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > ocp_pkg::NODE_DEPTH) return ocp_pkg::NODE_DEPTH;
    return 32'(v);
  endfunction

  // OX1 child of the stored parents; pushes one expected item per position
  function automatic void predict_crossover(input logic [ocp_pkg::NODE_W-1:0] cut_s,
                                            input logic [ocp_pkg::NODE_W-1:0] cut_e);
    int unsigned                n, lo, hi, tmp, cpos, ppos, reads;
    logic [ocp_pkg::NODE_W-1:0] child [ocp_pkg::NODE_DEPTH];
    bit                         placed [ocp_pkg::NODE_DEPTH];
    bit                         taken [ocp_pkg::NODE_DEPTH];
    logic                       broken;
    child_item_t                r;
    n = active_nodes(node_setting);
    lo = 32'(cut_s);
    hi = 32'(cut_e);
    if (lo > n - 1) lo = n - 1;
    if (hi > n - 1) hi = n - 1;
    if (lo > hi) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    for (int i = 0; i < ocp_pkg::NODE_DEPTH; i++) begin
      placed[i] = 1'b0;
      taken[i] = 1'b0;
      child[i] = '0;
    end
    // segment straight from the first parent
    for (int unsigned i = lo; i <= hi; i++) begin
      child[i] = tour_a[i];
      placed[i] = 1'b1;
      taken[tour_a[i]] = 1'b1;
    end
    // cyclic fill from the second parent, at most n reads
    cpos = (hi + 1) % n;
    ppos = cpos;
    reads = 0;
    while (cpos != lo && reads < n) begin
      if (!taken[tour_b[ppos]]) begin
        child[cpos] = tour_b[ppos];
        placed[cpos] = 1'b1;
        taken[tour_b[ppos]] = 1'b1;
        cpos = (cpos + 1) % n;
      end
      ppos = (ppos + 1) % n;
      reads++;
    end
    broken = (cpos != lo);
    for (int unsigned i = 0; i < n; i++) begin
      r.position = ocp_pkg::NODE_W'(i);
      r.node = placed[i] ? child[i] : '0;
      r.last = (i == n - 1);
      r.malformed = broken;
      awaited_children.push_back(r);
    end
  endfunction

  function automatic void shuffle_nodes(ref logic [ocp_pkg::NODE_W-1:0] v [ocp_pkg::NODE_DEPTH],
                                        input int cnt);
    int                         j;
    logic [ocp_pkg::NODE_W-1:0] t;
    for (int i = cnt - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = v[i];
      v[i] = v[j];
      v[j] = t;
    end
  endfunction

  // Present one item and hold it until accepted; update the predictor then
  task automatic send_item(input logic op, input logic [ocp_pkg::NODE_W-1:0] pos,
                           input logic [ocp_pkg::NODE_W-1:0] na,
                           input logic [ocp_pkg::NODE_W-1:0] nb,
                           input logic [ocp_pkg::NODE_W-1:0] cs,
                           input logic [ocp_pkg::NODE_W-1:0] ce,
                           input bit typed);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    position <= pos;
    first_parent_node <= na;
    second_parent_node <= nb;
    cut_start <= cs;
    cut_end <= ce;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (op == ocp_pkg::KIND_LOAD) begin
      tour_a[pos] = na;
      tour_b[pos] = nb;
    end else if (!typed) begin
      predict_crossover(cs, ce);
    end
  endtask

  // Drop valid, wait for every child item, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_children.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_node_count(input logic [ocp_pkg::CFG_W-1:0] v);
    settle();
    node_count_write <= 1'b1;
    node_count <= v;
    @(posedge clk);
    node_count_write <= 1'b0;
    node_setting = v;
  endtask

  // Well-formed parent pair: two orders of the same random node set
  task automatic load_tours(input int cnt);
    logic [ocp_pkg::NODE_W-1:0] pool [ocp_pkg::NODE_DEPTH];
    logic [ocp_pkg::NODE_W-1:0] other [ocp_pkg::NODE_DEPTH];
    for (int i = 0; i < ocp_pkg::NODE_DEPTH; i++) pool[i] = ocp_pkg::NODE_W'(i);
    shuffle_nodes(pool, ocp_pkg::NODE_DEPTH);
    other = pool;
    shuffle_nodes(other, cnt);
    for (int i = 0; i < cnt; i++) begin
      send_item(ocp_pkg::KIND_LOAD, ocp_pkg::NODE_W'(i), pool[i], other[i],
                ocp_pkg::NODE_W'($urandom), ocp_pkg::NODE_W'($urandom), 1'b0);
    end
    tours_whole = (cnt == ocp_pkg::NODE_DEPTH);
  endtask

  // Swap two positions in one or both parents; keeps permutations intact
  task automatic swap_nodes(input int cnt);
    int                         i, j, which;
    logic [ocp_pkg::NODE_W-1:0] ai, aj, bi, bj;
    i = $urandom_range(cnt - 1);
    j = $urandom_range(cnt - 1);
    which = $urandom_range(2);
    ai = tour_a[i];
    aj = tour_a[j];
    bi = tour_b[i];
    bj = tour_b[j];
    if (which != 1) begin
      ai = tour_a[j];
      aj = tour_a[i];
    end
    if (which != 0) begin
      bi = tour_b[j];
      bj = tour_b[i];
    end
    send_item(ocp_pkg::KIND_LOAD, ocp_pkg::NODE_W'(i), ai, bi,
              ocp_pkg::NODE_W'($urandom), ocp_pkg::NODE_W'($urandom), 1'b0);
    send_item(ocp_pkg::KIND_LOAD, ocp_pkg::NODE_W'(j), aj, bj,
              ocp_pkg::NODE_W'($urandom), ocp_pkg::NODE_W'($urandom), 1'b0);
  endtask

  // One random phase: new node count, fresh or tweaked parents, a few runs
  task automatic crossover_phase();
    int                        pick, ne, runs, lim;
    logic [ocp_pkg::CFG_W-1:0] setting;
    pick = $urandom_range(99);
    if (pick < 6) setting = 7'd64;
    else if (pick < 10) setting = ocp_pkg::CFG_W'($urandom_range(127, 65));
    else if (pick < 16) setting = 7'd1;
    else if (pick < 20) setting = '0;
    else setting = ocp_pkg::CFG_W'($urandom_range(16, 2));
    set_node_count(setting);
    ne = active_nodes(setting);
    if (ne < ocp_pkg::NODE_DEPTH || !tours_whole || $urandom_range(3) == 0) begin
      load_tours(ne);
    end
    if ($urandom_range(1) == 0) swap_nodes(ne);
    // corrupt a parent now and then so the scan bound gets hit
    if ($urandom_range(4) == 0) begin
      send_item(ocp_pkg::KIND_LOAD, ocp_pkg::NODE_W'($urandom_range(ne - 1)),
                ocp_pkg::NODE_W'($urandom), ocp_pkg::NODE_W'($urandom),
                ocp_pkg::NODE_W'($urandom), ocp_pkg::NODE_W'($urandom), 1'b0);
      tours_whole = 1'b0;
    end
    runs = $urandom_range(5, 2);
    repeat (runs) begin
      lim = ($urandom_range(9) < 7) ? ne - 1 : ocp_pkg::NODE_DEPTH - 1;
      send_item(ocp_pkg::KIND_RUN, ocp_pkg::NODE_W'($urandom),
                ocp_pkg::NODE_W'($urandom), ocp_pkg::NODE_W'($urandom),
                ocp_pkg::NODE_W'($urandom_range(lim)),
                ocp_pkg::NODE_W'($urandom_range(lim)), 1'b0);
    end
  endtask

  // Child item checker and receiver throttle
  always @(posedge clk) begin : child_check
    child_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_children.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected child item pos=%0d node=%0d last=%0b bad=%0b",
                     $realtime, child_position, child_node, last, malformed);
        end else begin
          want = awaited_children.pop_front();
          if (child_position !== want.position || child_node !== want.node ||
              last !== want.last || malformed !== want.malformed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: child mismatch exp pos=%0d node=%0d last=%0b bad=%0b, %s",
                       $realtime, want.position, want.node, want.last, want.malformed,
                       $sformatf("got pos=%0d node=%0d last=%0b bad=%0b",
                                 child_position, child_node, last, malformed));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Main sequence
  initial begin : stimulus
    child_item_t r;
    int          quota [3];
    quota = '{190, 330, 460};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct = 31;
    recv_stall_pct = 66;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].set_count) set_node_count(plan[i].count_value);
      send_item(plan[i].op, plan[i].pos, plan[i].node_a, plan[i].node_b,
                plan[i].cut_s, plan[i].cut_e, plan[i].typed_count != 0);
      for (int k = 0; k < plan[i].typed_count; k++) begin
        r.position = ocp_pkg::NODE_W'(k);
        r.node = (k == 0) ? plan[i].node0 : plan[i].node1;
        r.last = (k == plan[i].typed_count - 1);
        r.malformed = plan[i].bad;
        awaited_children.push_back(r);
      end
    end

    // fill every store entry before random cuts can reach it
    set_node_count(7'd64);
    load_tours(ocp_pkg::NODE_DEPTH);

    // random phases under three throttle modes
    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct = (mode == 0) ? 31 : (mode == 1) ? 66 : 0;
      recv_stall_pct = (mode == 0) ? 66 : (mode == 1) ? 31 : 0;
      while (items_sent < quota[mode]) crossover_phase();
    end

    settle();
    if (mismatches == 0 && awaited_children.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule

### order_crossover_permutation.f
sv/ocp_pkg.sv
sv/ocp_ram.sv
sv/ocp_ctrl.sv
sv/ocp_datapath.sv
sv/order_crossover_permutation.sv
sv/ocp_checker.sv
tb/order_crossover_permutation_tb.sv
